[rtl/core/ipv4_address_mask_table_defines.svh]
// Assertion macros used by the IPv4 address/mask table RTL.
`ifndef IPV4_ADDRESS_MASK_TABLE_DEFINES_SVH
`define IPV4_ADDRESS_MASK_TABLE_DEFINES_SVH

// Concurrent property checked on every clock edge outside reset.
`define AMT_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);

// Property whose consequence must hold in the cycle after its trigger.
`define AMT_ASSERT_NEXT(label, trig, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cons)) \
    else $error(msg);

`endif

[rtl/core/ipv4_amt_pkg.sv]
// Types and constants of the IPv4 address/mask table.
`timescale 1ns / 1ps

package ipv4_amt_pkg;

  localparam int unsigned ADDR_W  = 32;
  localparam int unsigned FUNC_W  = 2;
  localparam int unsigned POS_W   = 4;
  localparam int unsigned STAT_W  = 2;
  localparam int unsigned TOTAL_W = 5;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_FIND   = 2'd0,
    FUNC_ADD    = 2'd1,
    FUNC_REMOVE = 2'd2,
    FUNC_CLEAR  = 2'd3
  } func_t;

  typedef enum logic [STAT_W-1:0] {
    ST_DONE      = 2'd0,
    ST_NO_CHANGE = 2'd1,
    ST_FULL      = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SRCH_RD,
    S_SRCH_CMP,
    S_EXEC,
    S_SHIFT_RD,
    S_SHIFT_WR,
    S_RESP
  } state_t;

endpackage

[rtl/core/ipv4_amt_in_if.sv]
// Command channel of the IPv4 address/mask table.
`timescale 1ns / 1ps

interface ipv4_amt_in_if;
  logic                                valid;
  logic                                ready;
  logic [ipv4_amt_pkg::FUNC_W-1:0]     func;
  logic [ipv4_amt_pkg::ADDR_W-1:0]     addr;
  logic [ipv4_amt_pkg::ADDR_W-1:0]     net_mask;
  logic                                last_pair;

  modport source (output valid, func, addr, net_mask, last_pair, input ready);
  modport sink   (input valid, func, addr, net_mask, last_pair, output ready);
endinterface

[rtl/core/ipv4_amt_out_if.sv]
// Result channel of the IPv4 address/mask table.
`timescale 1ns / 1ps

interface ipv4_amt_out_if;
  logic                                valid;
  logic                                ready;
  logic                                hit;
  logic [ipv4_amt_pkg::POS_W-1:0]      position;
  logic [ipv4_amt_pkg::STAT_W-1:0]     status;
  logic [ipv4_amt_pkg::TOTAL_W-1:0]    entry_total;
  logic                                last_out;

  modport source (output valid, hit, position, status, entry_total, last_out, input ready);
  modport sink   (input valid, hit, position, status, entry_total, last_out, output ready);
endinterface

[rtl/core/ipv4_address_mask_table.sv]
// Top level of the IPv4 address/mask table: entry memory and search/compaction sequencer.
`timescale 1ns / 1ps
// Usage:
// The table holds up to DEPTH address/mask pairs packed at indexes 0 .. count-1.
// Commands arrive on in_if (valid/ready); each transaction carries func, addr,
// net_mask and last_pair. Every command yields exactly one result transaction on
// out_if with hit, position, status, entry_total and last_out.
// Commands are handled one at a time; in_if.ready is high only while idle.
// Sequence from acceptance to a valid result:
//   clear: empties the table and presents its result in the next cycle.
//   find/add/remove: the entries are compared one at a time, from the highest
//   entry down, stopping at the first match; an empty table is not searched.
//   A remove that hits then moves each entry above it down one place, one
//   entry at a time, before the result is presented.
// Each compare and each moved entry needs the single read port of the entry
// memory, so they run one after another.
// With a ready receiver the next command can be taken in the cycle after the
// result is delivered.
// Reset clears the entry count and the sequencer; memory contents are not
// cleared and are only read below the count. A stalled result holds on out_if
// and the block takes no new command until it is delivered.

`include "ipv4_address_mask_table_defines.svh"

module ipv4_address_mask_table #(
  parameter int unsigned DEPTH = 16
) (
  input  logic            clk,
  input  logic            rst_n,
  ipv4_amt_in_if.sink     in_if,
  ipv4_amt_out_if.source  out_if
);

  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam int unsigned IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned EW = 2 * ipv4_amt_pkg::ADDR_W;
  localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);

  ipv4_amt_pkg::state_t  state_r, state_nxt;
  logic [CW-1:0]         count_r, count_nxt;
  logic [IW-1:0]         idx_r, idx_nxt;
  logic                  hit_r, hit_nxt;
  logic [IW-1:0]         pos_r, pos_nxt;
  ipv4_amt_pkg::status_t status_r, status_nxt;
  ipv4_amt_pkg::func_t   func_r, func_nxt;
  logic [ipv4_amt_pkg::ADDR_W-1:0] addr_r, addr_nxt;
  logic [ipv4_amt_pkg::ADDR_W-1:0] mask_r, mask_nxt;
  logic                  last_r, last_nxt;

  // Entry memory: {address, mask} per entry, one write and one registered read.
  logic [EW-1:0] mem [DEPTH];
  logic [EW-1:0] rd_data_r;
  logic [IW-1:0] mem_ra;
  logic [IW-1:0] mem_wa;
  logic [EW-1:0] mem_wd;
  logic          mem_we;
  logic          in_accept;

  assign in_accept = in_if.valid && in_if.ready;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    rd_data_r <= mem[mem_ra];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ipv4_amt_pkg::S_IDLE;
      count_r <= '0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r    <= idx_nxt;
    hit_r    <= hit_nxt;
    pos_r    <= pos_nxt;
    status_r <= status_nxt;
    func_r   <= func_nxt;
    addr_r   <= addr_nxt;
    mask_r   <= mask_nxt;
    last_r   <= last_nxt;
  end

  always_comb begin
    state_nxt  = state_r;
    count_nxt  = count_r;
    idx_nxt    = idx_r;
    hit_nxt    = hit_r;
    pos_nxt    = pos_r;
    status_nxt = status_r;
    func_nxt   = func_r;
    addr_nxt   = addr_r;
    mask_nxt   = mask_r;
    last_nxt   = last_r;
    mem_ra     = idx_r;
    mem_we     = 1'b0;
    mem_wa     = idx_r;
    mem_wd     = {addr_r, mask_r};

    unique case (state_r)
      ipv4_amt_pkg::S_IDLE: begin
        if (in_if.valid) begin
          func_nxt   = ipv4_amt_pkg::func_t'(in_if.func);
          addr_nxt   = in_if.addr;
          mask_nxt   = in_if.net_mask;
          last_nxt   = in_if.last_pair;
          hit_nxt    = 1'b0;
          pos_nxt    = '0;
          status_nxt = ipv4_amt_pkg::ST_DONE;
          if (in_if.func == ipv4_amt_pkg::FUNC_CLEAR) begin
            count_nxt = '0;
            state_nxt = ipv4_amt_pkg::S_RESP;
          end else if (count_r == '0) begin
            state_nxt = ipv4_amt_pkg::S_EXEC;
          end else begin
            idx_nxt   = IW'(count_r - 1'b1);
            state_nxt = ipv4_amt_pkg::S_SRCH_RD;
          end
        end
      end
      ipv4_amt_pkg::S_SRCH_RD: begin
        mem_ra    = idx_r;
        state_nxt = ipv4_amt_pkg::S_SRCH_CMP;
      end
      ipv4_amt_pkg::S_SRCH_CMP: begin
        // The search runs downward, so the first match is the highest one.
        if (rd_data_r == {addr_r, mask_r}) begin
          hit_nxt   = 1'b1;
          pos_nxt   = idx_r;
          state_nxt = ipv4_amt_pkg::S_EXEC;
        end else if (idx_r == '0) begin
          state_nxt = ipv4_amt_pkg::S_EXEC;
        end else begin
          idx_nxt   = idx_r - 1'b1;
          state_nxt = ipv4_amt_pkg::S_SRCH_RD;
        end
      end
      ipv4_amt_pkg::S_EXEC: begin
        state_nxt = ipv4_amt_pkg::S_RESP;
        unique case (func_r)
          ipv4_amt_pkg::FUNC_FIND: begin
            status_nxt = hit_r ? ipv4_amt_pkg::ST_DONE : ipv4_amt_pkg::ST_NO_CHANGE;
          end
          ipv4_amt_pkg::FUNC_ADD: begin
            if (count_r >= DEPTH_C) begin
              status_nxt = ipv4_amt_pkg::ST_FULL;
            end else if (hit_r) begin
              status_nxt = ipv4_amt_pkg::ST_NO_CHANGE;
            end else begin
              mem_we    = 1'b1;
              mem_wa    = IW'(count_r);
              pos_nxt   = IW'(count_r);
              count_nxt = count_r + 1'b1;
            end
          end
          ipv4_amt_pkg::FUNC_REMOVE: begin
            if (hit_r) begin
              count_nxt = count_r - 1'b1;
              // Entries above the removed one move down one place each.
              if (CW'(pos_r) < CW'(count_r - 1'b1)) begin
                idx_nxt   = pos_r;
                state_nxt = ipv4_amt_pkg::S_SHIFT_RD;
              end
            end else begin
              status_nxt = ipv4_amt_pkg::ST_NO_CHANGE;
            end
          end
          ipv4_amt_pkg::FUNC_CLEAR: begin
            status_nxt = ipv4_amt_pkg::ST_DONE;
          end
        endcase
      end
      ipv4_amt_pkg::S_SHIFT_RD: begin
        mem_ra    = IW'(idx_r + 1'b1);
        state_nxt = ipv4_amt_pkg::S_SHIFT_WR;
      end
      ipv4_amt_pkg::S_SHIFT_WR: begin
        mem_we  = 1'b1;
        mem_wa  = idx_r;
        mem_wd  = rd_data_r;
        idx_nxt = IW'(idx_r + 1'b1);
        if ((CW'(idx_r) + 1'b1) < count_r) begin
          state_nxt = ipv4_amt_pkg::S_SHIFT_RD;
        end else begin
          state_nxt = ipv4_amt_pkg::S_RESP;
        end
      end
      ipv4_amt_pkg::S_RESP: begin
        if (out_if.ready) begin
          state_nxt = ipv4_amt_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = ipv4_amt_pkg::S_IDLE;
      end
    endcase
  end

  assign in_if.ready        = (state_r == ipv4_amt_pkg::S_IDLE);
  assign out_if.valid       = (state_r == ipv4_amt_pkg::S_RESP);
  assign out_if.hit         = hit_r;
  assign out_if.position    = ipv4_amt_pkg::POS_W'(pos_r);
  assign out_if.status      = status_r;
  assign out_if.entry_total = ipv4_amt_pkg::TOTAL_W'(count_r);
  assign out_if.last_out    = last_r;

  `AMT_ASSERT(a_count_bound, count_r <= DEPTH_C, "entry count exceeds table depth")
  `AMT_ASSERT(a_search_in_range,
    (state_r == ipv4_amt_pkg::S_SRCH_RD || state_r == ipv4_amt_pkg::S_SRCH_CMP)
      |-> (CW'(idx_r) < count_r), "search index outside the valid entries")
  `AMT_ASSERT(a_one_side_open, !(in_if.ready && out_if.valid),
    "command taken while a result is pending")
  `AMT_ASSERT_NEXT(a_clear_empties,
    in_accept && (in_if.func == ipv4_amt_pkg::FUNC_CLEAR),
    (count_r == '0) && (state_r == ipv4_amt_pkg::S_RESP), "clear did not empty the table")
  `AMT_ASSERT_NEXT(a_add_grows,
    (state_r == ipv4_amt_pkg::S_EXEC) && (func_r == ipv4_amt_pkg::FUNC_ADD) && mem_we,
    count_r == CW'($past(count_r) + 1'b1), "add stored an entry without counting it")

endmodule
